>>> hw/rtl/shlfr_pkg.sv
// package for the sync/header length-prefixed frame receiver
// holds payload structs, store request struct, parser codes and sizing constants
// no dependencies
package shlfr_pkg;

    localparam int BUFFER_DEPTH = 64;
    localparam int STORE_DEPTH  = 2 * BUFFER_DEPTH;
    localparam int ADDR_W       = $clog2(STORE_DEPTH);
    localparam int POS_W        = $clog2(BUFFER_DEPTH + 1);
    localparam int CMP_W        = (POS_W > 9) ? POS_W : 9;
    localparam int IDX_W        = 6;
    localparam int BYTE_W       = 8;
    localparam int CFG_IDX_W    = 2;

    localparam logic [1:0] PS_IDLE   = 2'd0;
    localparam logic [1:0] PS_HEADER = 2'd1;
    localparam logic [1:0] PS_DATA   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_BYTE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTE = 2'd1;

    localparam logic [BYTE_W-1:0] SYNC_RESET   = 8'hAA;
    localparam logic [BYTE_W-1:0] HEADER_RESET = 8'h55;

    typedef struct packed {
        logic              mode;
        logic [BYTE_W-1:0] rx_byte;
        logic [IDX_W-1:0]  read_index;
    } in_item_t;

    typedef struct packed {
        logic              frame_done;
        logic              frame_dropped;
        logic [BYTE_W-1:0] read_data;
    } out_item_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [BYTE_W-1:0] wr_data;
        logic              clr_en;
        logic              clr_half;
    } store_req_t;

    typedef struct packed {
        logic frame_done;
        logic frame_dropped;
    } parse_flags_t;

endpackage

>>> hw/rtl/sync_header_length_frame_receiver.sv
// sync/header length-prefixed frame receiver, top level
// a result passes the memory read register, then the output register
// throughput: one item per cycle unless m_ready back-pressure stalls the pipeline
// reset: aresetn (sync, active-low) clears parser and buffer valid bits, presets config
// depends on shlfr_pkg, shlfr_parser, shlfr_store
module sync_header_length_frame_receiver (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [shlfr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [shlfr_pkg::BYTE_W-1:0]        cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  shlfr_pkg::in_item_t                 s_item,
    output logic                                m_valid,
    input  logic                                m_ready,
    output shlfr_pkg::out_item_t                m_item
);

    logic                         accept;
    logic                         byte_en;
    logic                         rx_sel;
    shlfr_pkg::store_req_t        req;
    shlfr_pkg::parse_flags_t      flags;
    logic                         rd_en;
    logic                         rd_in_range;
    logic [shlfr_pkg::ADDR_W-1:0] rd_addr;
    logic [shlfr_pkg::BYTE_W-1:0] rd_data;

    logic                         p1_valid_reg;
    shlfr_pkg::parse_flags_t      p1_flags_reg;
    logic                         p1_read_reg;
    logic                         p1_adv;
    logic                         out_valid_reg;
    shlfr_pkg::out_item_t         out_reg;

    assign p1_adv  = p1_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !p1_valid_reg || p1_adv;
    assign accept  = s_valid && s_ready;
    assign byte_en = accept && !s_item.mode;

    assign rd_in_range = shlfr_pkg::CMP_W'(s_item.read_index) <
                         shlfr_pkg::CMP_W'(shlfr_pkg::BUFFER_DEPTH);
    assign rd_en       = accept && s_item.mode;
    assign rd_addr     = rx_sel
                       ? shlfr_pkg::ADDR_W'(s_item.read_index)
                       : shlfr_pkg::ADDR_W'(shlfr_pkg::BUFFER_DEPTH)
                         + shlfr_pkg::ADDR_W'(s_item.read_index);

    shlfr_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .byte_en   (byte_en),
        .rx_byte   (s_item.rx_byte),
        .rx_sel    (rx_sel),
        .req       (req),
        .flags     (flags)
    );

    shlfr_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (accept) begin
            p1_valid_reg <= 1'b1;
        end else if (p1_adv) begin
            p1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_flags_reg <= flags;
            p1_read_reg  <= s_item.mode && rd_in_range;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (p1_adv) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_adv) begin
            out_reg.frame_done    <= p1_flags_reg.frame_done;
            out_reg.frame_dropped <= p1_flags_reg.frame_dropped;
            out_reg.read_data     <= p1_read_reg ? rd_data : '0;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_reg;

endmodule

>>> hw/rtl/shlfr_store.sv
// double frame buffer memory with per-entry valid bits
// depends on shlfr_pkg
module shlfr_store (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  shlfr_pkg::store_req_t               req,
    input  logic                                rd_en,
    input  logic [shlfr_pkg::ADDR_W-1:0]        rd_addr,
    output logic [shlfr_pkg::BYTE_W-1:0]        rd_data
);

    logic [shlfr_pkg::BYTE_W-1:0]      mem [shlfr_pkg::STORE_DEPTH];
    logic [shlfr_pkg::STORE_DEPTH-1:0] valid_reg;
    logic [shlfr_pkg::STORE_DEPTH-1:0] valid_next;
    logic [shlfr_pkg::BYTE_W-1:0]      rd_data_reg;
    logic                              rd_valid_reg;

    always_comb begin
        valid_next = valid_reg;
        if (req.wr_en) begin
            valid_next[req.wr_addr] = 1'b1;
        end
        if (req.clr_en) begin
            for (int i = 0; i < shlfr_pkg::BUFFER_DEPTH; i++) begin
                if (req.clr_half) begin
                    valid_next[shlfr_pkg::BUFFER_DEPTH + i] = 1'b0;
                end else begin
                    valid_next[i] = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg  <= mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

>>> hw/rtl/shlfr_parser.sv
// frame parser: sync/header detection, write position, length tracking, buffer select
// depends on shlfr_pkg
module shlfr_parser (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [shlfr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [shlfr_pkg::BYTE_W-1:0]        cfg_wdata,
    input  logic                                byte_en,
    input  logic [shlfr_pkg::BYTE_W-1:0]        rx_byte,
    output logic                                rx_sel,
    output shlfr_pkg::store_req_t               req,
    output shlfr_pkg::parse_flags_t             flags
);

    logic [shlfr_pkg::BYTE_W-1:0] sync_byte_reg;
    logic [shlfr_pkg::BYTE_W-1:0] header_byte_reg;
    logic [1:0]                   parse_state_reg, parse_state_next;
    logic [shlfr_pkg::POS_W-1:0]  write_pos_reg, write_pos_next;
    logic [shlfr_pkg::BYTE_W-1:0] frame_len_reg, frame_len_next;
    logic                         rx_sel_reg, rx_sel_next;
    logic [shlfr_pkg::CMP_W-1:0]  end_pos;
    logic [shlfr_pkg::ADDR_W-1:0] pos_addr;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_byte_reg   <= shlfr_pkg::SYNC_RESET;
            header_byte_reg <= shlfr_pkg::HEADER_RESET;
        end else if (cfg_wr_en) begin
            if (cfg_index == shlfr_pkg::CFG_SYNC_BYTE) begin
                sync_byte_reg <= cfg_wdata;
            end else if (cfg_index == shlfr_pkg::CFG_HEADER_BYTE) begin
                header_byte_reg <= cfg_wdata;
            end
        end
    end

    assign end_pos  = shlfr_pkg::CMP_W'(frame_len_reg) + shlfr_pkg::CMP_W'(2);
    assign pos_addr = rx_sel_reg
                    ? shlfr_pkg::ADDR_W'(shlfr_pkg::BUFFER_DEPTH) + shlfr_pkg::ADDR_W'(write_pos_reg)
                    : shlfr_pkg::ADDR_W'(write_pos_reg);

    always_comb begin
        parse_state_next = parse_state_reg;
        write_pos_next   = write_pos_reg;
        frame_len_next   = frame_len_reg;
        rx_sel_next      = rx_sel_reg;
        req              = '0;
        req.wr_addr      = pos_addr;
        req.wr_data      = rx_byte;
        flags            = '0;
        if (byte_en) begin
            case (parse_state_reg)
                shlfr_pkg::PS_HEADER: begin
                    parse_state_next = (rx_byte == header_byte_reg)
                                     ? shlfr_pkg::PS_DATA : shlfr_pkg::PS_IDLE;
                end
                shlfr_pkg::PS_DATA: begin
                    if (shlfr_pkg::CMP_W'(write_pos_reg) >=
                        shlfr_pkg::CMP_W'(shlfr_pkg::BUFFER_DEPTH)) begin
                        flags.frame_dropped = 1'b1;
                        parse_state_next    = shlfr_pkg::PS_IDLE;
                        write_pos_next      = '0;
                        req.clr_en          = 1'b1;
                        req.clr_half        = rx_sel_reg;
                    end else begin
                        req.wr_en = 1'b1;
                        if (write_pos_reg == shlfr_pkg::POS_W'(1)) begin
                            frame_len_next = rx_byte;
                        end
                        // position 1 can never be the end position
                        if (write_pos_reg != shlfr_pkg::POS_W'(1) &&
                            shlfr_pkg::CMP_W'(write_pos_reg) == end_pos) begin
                            flags.frame_done = 1'b1;
                            parse_state_next = shlfr_pkg::PS_IDLE;
                            write_pos_next   = '0;
                            rx_sel_next      = ~rx_sel_reg;
                            req.clr_en       = 1'b1;
                            req.clr_half     = ~rx_sel_reg;
                        end else begin
                            write_pos_next = write_pos_reg + shlfr_pkg::POS_W'(1);
                        end
                    end
                end
                default: begin
                    parse_state_next = (rx_byte == sync_byte_reg)
                                     ? shlfr_pkg::PS_HEADER : shlfr_pkg::PS_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            parse_state_reg <= shlfr_pkg::PS_IDLE;
            write_pos_reg   <= '0;
            frame_len_reg   <= '0;
            rx_sel_reg      <= 1'b0;
        end else begin
            parse_state_reg <= parse_state_next;
            write_pos_reg   <= write_pos_next;
            frame_len_reg   <= frame_len_next;
            rx_sel_reg      <= rx_sel_next;
        end
    end

    assign rx_sel = rx_sel_reg;

endmodule
